@@ hdl/ptmg_pkg.sv @@
package ptmg_pkg;

  localparam int COLOR_WIDTH_DEF      = 24;
  localparam int GAMMA_INDEX_BITS_DEF = 10;

  // Fraction bits of the sums and of the exposure gain.
  localparam int SUM_FRAC_BITS  = 12;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int COUNT_W    = 9;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;

  // Stages besides the divider steps: product, denominator, gamma lookup.
  localparam int EXTRA_STAGES = 3;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET  = 9'd10;
  localparam logic [GAIN_W-1:0]  EXPOSURE_GAIN_RESET = 16'd256;

  typedef enum logic [0:0] {
    REG_SAMPLE_COUNT  = 1'b0,
    REG_EXPOSURE_GAIN = 1'b1
  } cfg_reg_t;

endpackage

@@ hdl/ptmg_channel.sv @@
module ptmg_channel #(
  parameter int COLOR_WIDTH      = ptmg_pkg::COLOR_WIDTH_DEF,
  parameter int GAMMA_INDEX_BITS = ptmg_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic [GAMMA_INDEX_BITS+2:0]  en,
  input  logic [COLOR_WIDTH-1:0]       channel_sum,
  input  logic [ptmg_pkg::COUNT_W-1:0] sample_count,
  input  logic [ptmg_pkg::GAIN_W-1:0]  exposure_gain,
  output logic [7:0]                   channel_byte
);

  localparam int G        = GAMMA_INDEX_BITS;
  localparam int P_W      = COLOR_WIDTH + ptmg_pkg::GAIN_W;
  localparam int Q_W      = P_W + 1;
  localparam int ROM_SIZE = 1 << G;
  localparam int WIDE_W   = 160;
  localparam int ROM_STAGE = G + 2;

  typedef logic [7:0] rom_t [ROM_SIZE];

  // Entry i is the largest v with v^11 * 2^(5*G) <= i^5 * 2^88,
  // i.e. floor(256 * (i / 2^G)^(1/2.2)).
  function automatic rom_t build_rom();
    rom_t              rom;
    logic [WIDE_W-1:0] rhs;
    logic [WIDE_W-1:0] lhs;
    int                v;
    bit                fits;
    v = 0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      rhs = WIDE_W'(1);
      for (int k = 0; k < 5; k++) rhs = rhs * WIDE_W'(i);
      rhs  = rhs << 88;
      fits = 1'b1;
      while (v < 255 && fits) begin
        lhs = WIDE_W'(1);
        for (int k = 0; k < 11; k++) lhs = lhs * WIDE_W'(v + 1);
        lhs = lhs << (5 * G);
        if (lhs <= rhs) v = v + 1;
        else fits = 1'b0;
      end
      rom[i] = 8'(v);
    end
    return rom;
  endfunction

  localparam rom_t GAMMA_ROM = build_rom();

  logic [P_W-1:0]               prod;
  logic [P_W-1:0]               prod_reg;
  logic [ptmg_pkg::COUNT_W-1:0] count;
  logic [Q_W-1:0]               count_scaled;
  logic [Q_W-1:0]               rem [G];
  logic [Q_W-1:0]               den [G];
  logic [G-1:0]                 quo [G+1];

  assign prod = channel_sum * exposure_gain;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_reg <= prod;
    end
  end

  // A count of zero divides as one.
  assign count = (sample_count == '0) ? ptmg_pkg::COUNT_W'(1) : sample_count;
  assign count_scaled = Q_W'(count) << (ptmg_pkg::SUM_FRAC_BITS + ptmg_pkg::GAIN_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0] <= Q_W'(prod_reg);
      den[0] <= Q_W'(prod_reg) + count_scaled;
      quo[0] <= '0;
    end
  end

  // One restoring quotient bit per stage; only the top G bits reach the ROM.
  for (genvar j = 1; j <= G; j++) begin : g_div
    logic [Q_W:0] shifted;
    logic         take;

    assign shifted = {rem[j-1], 1'b0};
    assign take    = shifted >= {1'b0, den[j-1]};

    always_ff @(posedge clk) begin
      if (en[1+j]) begin
        quo[j] <= {quo[j-1][G-2:0], take};
      end
    end

    if (j < G) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[1+j]) begin
          rem[j] <= take ? Q_W'(shifted - {1'b0, den[j-1]}) : shifted[Q_W-1:0];
          den[j] <= den[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ROM_STAGE]) begin
      channel_byte <= GAMMA_ROM[quo[G]];
    end
  end

endmodule

@@ hdl/pixel_tone_map_gamma.sv @@
// Stages from input transfer to output valid: product, denominator,
// one stage per quotient bit of the divider, gamma ROM read.
// Throughput: one pixel per clock while out_stall is low; every stage holds its own item.
// Reset clears all stage valid bits and loads sample_count 10, exposure 1.0.
module pixel_tone_map_gamma #(
  parameter int COLOR_WIDTH      = ptmg_pkg::COLOR_WIDTH_DEF,
  parameter int GAMMA_INDEX_BITS = ptmg_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [ptmg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COLOR_WIDTH-1:0]          red_sum,
  input  logic [COLOR_WIDTH-1:0]          green_sum,
  input  logic [COLOR_WIDTH-1:0]          blue_sum,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      red_byte,
  output logic [7:0]                      green_byte,
  output logic [7:0]                      blue_byte
);

  localparam int STAGES = GAMMA_INDEX_BITS + ptmg_pkg::EXTRA_STAGES;

  logic [ptmg_pkg::COUNT_W-1:0] sample_count;
  logic [ptmg_pkg::GAIN_W-1:0]  exposure_gain;
  logic [STAGES-1:0]            valid;
  logic [STAGES-1:0]            en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= ptmg_pkg::SAMPLE_COUNT_RESET;
      exposure_gain <= ptmg_pkg::EXPOSURE_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ptmg_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg_data[ptmg_pkg::COUNT_W-1:0];
        ptmg_pkg::REG_EXPOSURE_GAIN: exposure_gain <= cfg_data[ptmg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances,
  // so bubbles collapse while the output is held.
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[STAGES-1];

  ptmg_channel #(
    .COLOR_WIDTH      (COLOR_WIDTH),
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_red (
    .clk           (clk),
    .en            (en),
    .channel_sum   (red_sum),
    .sample_count  (sample_count),
    .exposure_gain (exposure_gain),
    .channel_byte  (red_byte)
  );

  ptmg_channel #(
    .COLOR_WIDTH      (COLOR_WIDTH),
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_green (
    .clk           (clk),
    .en            (en),
    .channel_sum   (green_sum),
    .sample_count  (sample_count),
    .exposure_gain (exposure_gain),
    .channel_byte  (green_byte)
  );

  ptmg_channel #(
    .COLOR_WIDTH      (COLOR_WIDTH),
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_blue (
    .clk           (clk),
    .en            (en),
    .channel_sum   (blue_sum),
    .sample_count  (sample_count),
    .exposure_gain (exposure_gain),
    .channel_byte  (blue_byte)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CW           = ptmg_pkg::COLOR_WIDTH_DEF;
  localparam int GIB          = ptmg_pkg::GAMMA_INDEX_BITS_DEF;
  localparam int CFG_W        = ptmg_pkg::CFG_DATA_W;
  localparam int TONE_BITS    = 16;
  localparam int LATENCY      = GIB + ptmg_pkg::EXTRA_STAGES;
  localparam int IDLE_LIMIT   = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 344;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_bytes_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  ptmg_pkg::cfg_reg_t   cfg_index = ptmg_pkg::REG_SAMPLE_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CW-1:0]        red_sum = '0;
  logic [CW-1:0]        green_sum = '0;
  logic [CW-1:0]        blue_sum = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           red_byte;
  logic [7:0]           green_byte;
  logic [7:0]           blue_byte;

  // local copy of the register file and the display curve
  logic [ptmg_pkg::COUNT_W-1:0] count_reg = ptmg_pkg::SAMPLE_COUNT_RESET;
  logic [ptmg_pkg::GAIN_W-1:0]  gain_reg = ptmg_pkg::EXPOSURE_GAIN_RESET;
  logic [7:0]                   display_curve [0:(1 << GIB) - 1];

  pixel_bytes_t expected_pixels [$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int           mode_left = 0;
  int           stall_phase = 0;

  pixel_tone_map_gamma #(
    .COLOR_WIDTH      (CW),
    .GAMMA_INDEX_BITS (GIB)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red_sum    (red_sum),
    .green_sum  (green_sum),
    .blue_sum   (blue_sum),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_byte   (red_byte),
    .green_byte (green_byte),
    .blue_byte  (blue_byte)
  );

  always #10 clk = ~clk;

  // v is in the curve at index i when v^11 * 2^(5*GIB) <= i^5 * 256^11
  function automatic bit curve_holds(input int v, input logic [191:0] bound);
    logic [191:0] lhs;
    lhs = 192'd1;
    for (int k = 0; k < 11; k++) lhs = lhs * 192'(v);
    lhs = lhs << (5 * GIB);
    return lhs <= bound;
  endfunction

  function automatic void fill_display_curve();
    logic [191:0] bound;
    int           v;
    v = 0;
    for (int i = 0; i < (1 << GIB); i++) begin
      bound = 192'd1;
      for (int k = 0; k < 5; k++) bound = bound * 192'(i);
      bound = bound << (8 * 11);
      while (v < 255 && curve_holds(v + 1, bound)) v++;
      display_curve[i] = v[7:0];
    end
  endfunction

  // x/(1+x) by restoring division, then the curve lookup on the top bits
  function automatic logic [7:0] channel_byte(input logic [CW-1:0] sum);
    logic [63:0]          prod;
    logic [63:0]          denom;
    logic [63:0]          rem;
    logic [TONE_BITS-1:0] tone;
    logic [63:0]          count;
    count = (count_reg == '0) ? 64'd1 : 64'(count_reg);
    prod  = 64'(sum) * 64'(gain_reg);
    denom = prod + (count << (ptmg_pkg::SUM_FRAC_BITS + ptmg_pkg::GAIN_FRAC_BITS));
    rem   = prod;
    tone  = '0;
    for (int k = 0; k < TONE_BITS; k++) begin
      rem  = rem << 1;
      tone = tone << 1;
      if (rem >= denom) begin
        rem     = rem - denom;
        tone[0] = 1'b1;
      end
    end
    return display_curve[tone[TONE_BITS-1 -: GIB]];
  endfunction

  // predict on every input transfer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_pixels.insert(expected_pixels.size(),
                             {channel_byte(red_sum), channel_byte(green_sum),
                              channel_byte(blue_sum)});
  end

  always @(posedge clk) begin : check_results
    pixel_bytes_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                   red_byte, green_byte, blue_byte);
      end else begin
        want = expected_pixels.pop_front();
        if (want.red !== red_byte || want.green !== green_byte ||
            want.blue !== blue_byte) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     red_byte, green_byte, blue_byte);
        end
      end
    end
  end

  // receiver backpressure: switch between randomly chosen stall styles
  always @(posedge clk) begin
    if (!rst) begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_EVERY_THIRD));
        mode_left  = $urandom_range(8, 60);
      end
      mode_left--;
      stall_phase = (stall_phase + 1) % 3;
      case (stall_mode)
        STALL_NONE:        out_stall <= 1'b0;
        STALL_LIGHT:       out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY:       out_stall <= ($urandom_range(0, 9) < 7);
        STALL_EVERY_THIRD: out_stall <= (stall_phase == 0);
        default:           out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pixel_tone_map_gamma regression: fail");
      $finish;
    end
  end

  // one pixel transfer; the sender runs in bursts separated by random gaps
  task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                            input logic [CW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid  <= 1'b1;
    red_sum   <= r;
    green_sum <= g;
    blue_sum  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // hold the input and wait until every predicted pixel has come out;
  // the first edge lets the last transfer reach the prediction queue
  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // write both registers on back-to-back edges; the block is idle here
  task automatic set_config(input logic [CFG_W-1:0] count_data,
                            input logic [CFG_W-1:0] gain_data);
    drain_pixels();
    cfg_write <= 1'b1;
    cfg_index <= ptmg_pkg::REG_SAMPLE_COUNT;
    cfg_data  <= count_data;
    @(posedge clk);
    count_reg = count_data[ptmg_pkg::COUNT_W-1:0];
    cfg_index <= ptmg_pkg::REG_EXPOSURE_GAIN;
    cfg_data  <= gain_data;
    @(posedge clk);
    gain_reg = gain_data[ptmg_pkg::GAIN_W-1:0];
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CW-1:0] random_sum();
    int width;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CW'($urandom);
      default: begin
        width = $urandom_range(1, CW);
        return CW'($urandom) & CW'((64'd1 << width) - 1);
      end
    endcase
  endfunction

  task automatic test_reset_settings();
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    // 10 samples of 1.0 each give x = 1.0, halfway up the tone curve
    send_pixel(CW'(10 << ptmg_pkg::SUM_FRAC_BITS), '0, 24'h000001);
    send_pixel(24'h800000, 24'h00A000, 24'h7FFFFF);
    send_pixel(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
  endtask

  task automatic test_extreme_settings();
    // zero count acts as one sample, full gain
    set_config(16'd0, 16'hFFFF);
    send_pixel('1, 24'h000001, '0);
    send_pixel(24'h000001, '0, 24'h000100);
    send_pixel(24'hFFF000, 24'h001000, 24'h000FFF);
    // zero gain forces black
    set_config(16'd256, 16'd0);
    send_pixel('1, 24'h123456, 24'h000001);
    // upper data bits beyond the count width are dropped
    set_config(16'hFFFF, 16'd1);
    send_pixel('1, '1, 24'h001000);
    send_pixel(24'h7FFFFF, 24'h000000, 24'hFFFFFE);
    set_config(16'd1, 16'd256);
    send_pixel(24'h000FFF, 24'h001000, 24'h002000);
    send_pixel(24'h000001, 24'h0FFFFF, '1);
    set_config(16'd256, 16'hFFFF);
    send_pixel('1, 24'h010000, 24'h000100);
    send_pixel(24'h100000, 24'h000010, 24'h000000);
  endtask

  task automatic test_random_settings();
    logic [CFG_W-1:0] count_data;
    logic [CFG_W-1:0] gain_data;
    int               phase_items;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0:       count_data = 16'd1;
        1:       count_data = 16'd256;
        2:       count_data = CFG_W'($urandom);
        default: count_data = CFG_W'($urandom_range(1, 256));
      endcase
      case ($urandom_range(0, 4))
        0:       gain_data = 16'hFFFF;
        1:       gain_data = 16'd256;
        2:       gain_data = CFG_W'($urandom_range(0, 255));
        default: gain_data = CFG_W'($urandom);
      endcase
      set_config(count_data, gain_data);
      phase_items = RANDOM_ITEMS / 8;
      for (int n = 0; n < phase_items; n++)
        send_pixel(random_sum(), random_sum(), random_sum());
    end
  endtask

  task automatic test_mid_stream_pause();
    set_config(16'd10, 16'd256);
    repeat (20) send_pixel(random_sum(), random_sum(), random_sum());
    drain_pixels();
    repeat (20) send_pixel(random_sum(), random_sum(), random_sum());
  endtask

  initial begin
    fill_display_curve();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_extreme_settings();
    test_mid_stream_pause();
    test_random_settings();
    drain_pixels();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("pixel_tone_map_gamma regression: pass");
    else
      $display("pixel_tone_map_gamma regression: fail");
    $finish;
  end

endmodule
